// ----- src/lst_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lst_pkg: shared definitions for the LRU address slot table
// Field widths, parameter defaults and comparator mode codes.
// ---------------------------------------------------------------------------
package lst_pkg;

	// parameter defaults
	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_ADDRESS_BITS = 48;

	// fixed field widths
	localparam int STAMP_W = 48;
	localparam int COUNT_W = 32;
	localparam int SLOT_W  = 6;
	localparam int OCC_W   = 7;

	// shared comparator modes
	localparam logic CMP_ADDR  = 1'b0;
	localparam logic CMP_STAMP = 1'b1;

endpackage

// ----- src/lru_address_slot_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_address_slot_table: fully associative address table, LRU replacement
// Sequencer walks the entry store through one shared comparator: a lookup
// pass over occupied entries, then on a full-table miss an oldest-stamp pass.
// ---------------------------------------------------------------------------
// An empty table skips the lookup pass and writes the first entry; otherwise the lookup pass
// reads occupied entries up to a hit or the last one, and a miss on a full table adds the
// stamp search, each pass at one entry a cycle, set by the single store read port.
// The result register lets the next word be accepted while a result waits. Reset clears
// counters and control only; the entry store is not cleared and needs no clearing pass.
module lru_address_slot_table #(
	parameter int TABLE_DEPTH  = lst_pkg::DEF_TABLE_DEPTH,
	parameter int ADDRESS_BITS = lst_pkg::DEF_ADDRESS_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ADDRESS_BITS-1:0]     address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lst_pkg::SLOT_W-1:0]  slot,
	output logic                        hit,
	output logic                        evicted,
	output logic [lst_pkg::COUNT_W-1:0] use_count,
	output logic [lst_pkg::OCC_W-1:0]   occupied
);
	import lst_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SRCH  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;

	logic [2:0]              state_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [STAMP_W-1:0]      now_q;
	logic [STAMP_W-1:0]      clock_q;
	logic [CNT_W-1:0]        fill_q;
	logic [COUNT_W-1:0]      evict_total_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    rvld_s1;
	logic [IDX_W-1:0]        ridx_s1;
	logic [STAMP_W-1:0]      min_q;
	logic [IDX_W-1:0]        min_idx_q;
	logic [IDX_W-1:0]        slot_q;
	logic [COUNT_W-1:0]      cnt_q;
	logic                    hit_q;
	logic                    evict_q;

	logic                    out_valid_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic                    out_hit_q;
	logic                    out_evict_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic [OCC_W-1:0]        out_occ_q;

	logic                    issue;
	logic                    cmp_mode;
	logic                    cmp_eq;
	logic                    cmp_lt;
	logic                    take_new;
	logic                    wr_go;
	logic                    in_acc;
	logic [ADDRESS_BITS-1:0] rd_addr;
	logic [COUNT_W-1:0]      rd_count;
	logic [STAMP_W-1:0]      rd_stamp;
	logic [COUNT_W-1:0]      rd_count_inc;
	logic                    scan_last;
	logic                    srch_last;
	logic                    table_full;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// read issue for whichever pass is running
	always_comb begin
		issue = 1'b0;
		case (state_q)
			ST_SCAN: issue = (ptr_q < fill_q);
			ST_SRCH: issue = (ptr_q < CNT_W'(TABLE_DEPTH));
			default: issue = 1'b0;
		endcase
	end

	assign cmp_mode     = (state_q == ST_SRCH) ? CMP_STAMP : CMP_ADDR;
	assign rd_count_inc = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);
	assign scan_last    = (CNT_W'(ridx_s1) + CNT_W'(1)) == fill_q;
	assign srch_last    = (ridx_s1 == IDX_W'(TABLE_DEPTH - 1));
	assign table_full   = (fill_q == CNT_W'(TABLE_DEPTH));
	assign take_new     = (ridx_s1 == '0) || cmp_lt;
	assign wr_go        = (state_q == ST_WRITE) && (!out_valid_q || out_ready);

	lst_ram #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ADDR_W     (ADDRESS_BITS),
		.IDX_W      (IDX_W)
	) u_ram (
		.clk     (clk),
		.we      (wr_go),
		.waddr   (slot_q),
		.wr_addr (addr_q),
		.wr_count(cnt_q),
		.wr_stamp(now_q),
		.re      (issue),
		.raddr   (ptr_q[IDX_W-1:0]),
		.rd_addr (rd_addr),
		.rd_count(rd_count),
		.rd_stamp(rd_stamp)
	);

	lst_cmp #(
		.ADDR_W(ADDRESS_BITS)
	) u_cmp (
		.mode   (cmp_mode),
		.addr_a (rd_addr),
		.addr_b (addr_q),
		.stamp_a(rd_stamp),
		.stamp_b(min_q),
		.eq     (cmp_eq),
		.lt     (cmp_lt)
	);

	// sequencer and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			clock_q       <= '0;
			fill_q        <= '0;
			evict_total_q <= '0;
			ptr_q         <= '0;
			rvld_s1       <= 1'b0;
		end else begin
			rvld_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						clock_q <= clock_q + STAMP_W'(1);
						ptr_q   <= '0;
						if (fill_q == '0) begin
							fill_q  <= CNT_W'(1);
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rvld_s1 && cmp_eq) begin
						state_q <= ST_WRITE;
					end else if (rvld_s1 && scan_last) begin
						if (table_full) begin
							ptr_q   <= '0;
							state_q <= ST_SRCH;
						end else begin
							fill_q  <= fill_q + CNT_W'(1);
							state_q <= ST_WRITE;
						end
					end
				end
				ST_SRCH: begin
					if (rvld_s1 && srch_last) begin
						evict_total_q <= evict_total_q + COUNT_W'(1);
						state_q       <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wr_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q  <= address;
				now_q   <= clock_q;
				slot_q  <= '0;
				cnt_q   <= COUNT_W'(1);
				hit_q   <= 1'b0;
				evict_q <= 1'b0;
			end
			ST_SCAN: begin
				if (rvld_s1 && cmp_eq) begin
					slot_q <= ridx_s1;
					cnt_q  <= rd_count_inc;
					hit_q  <= 1'b1;
				end else if (rvld_s1 && scan_last) begin
					slot_q <= fill_q[IDX_W-1:0];
				end
			end
			ST_SRCH: begin
				if (rvld_s1 && take_new) begin
					min_q     <= rd_stamp;
					min_idx_q <= ridx_s1;
				end
				if (rvld_s1 && srch_last) begin
					slot_q  <= take_new ? ridx_s1 : min_idx_q;
					evict_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		ridx_s1 <= ptr_q[IDX_W-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			out_slot_q  <= SLOT_W'(slot_q);
			out_hit_q   <= hit_q;
			out_evict_q <= evict_q;
			out_count_q <= cnt_q;
			out_occ_q   <= OCC_W'(fill_q);
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = out_slot_q;
	assign hit       = out_hit_q;
	assign evicted   = out_evict_q;
	assign use_count = out_count_q;
	assign occupied  = out_occ_q;

endmodule

// ----- src/lst_cmp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lst_cmp: shared compare unit
// Selects address or stamp operands by mode and gives equal and less-than.
// ---------------------------------------------------------------------------
module lst_cmp #(
	parameter int ADDR_W = lst_pkg::DEF_ADDRESS_BITS
) (
	input  logic                      mode,
	input  logic [ADDR_W-1:0]         addr_a,
	input  logic [ADDR_W-1:0]         addr_b,
	input  logic [lst_pkg::STAMP_W-1:0] stamp_a,
	input  logic [lst_pkg::STAMP_W-1:0] stamp_b,
	output logic                      eq,
	output logic                      lt
);
	import lst_pkg::*;

	localparam int CMP_W = (ADDR_W > STAMP_W) ? ADDR_W : STAMP_W;

	logic [CMP_W-1:0] op_a;
	logic [CMP_W-1:0] op_b;

	// operand select, zero extended to the common width
	always_comb begin
		if (mode == CMP_STAMP) begin
			op_a = CMP_W'(stamp_a);
			op_b = CMP_W'(stamp_b);
		end else begin
			op_a = CMP_W'(addr_a);
			op_b = CMP_W'(addr_b);
		end
	end

	// one magnitude comparator serves both passes
	assign eq = (op_a == op_b);
	assign lt = (op_a < op_b);

endmodule

// ----- src/lst_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lst_ram: entry store
// One write port and one registered read port over address, count, stamp.
// ---------------------------------------------------------------------------
module lst_ram #(
	parameter int TABLE_DEPTH = lst_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_W      = lst_pkg::DEF_ADDRESS_BITS,
	parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [IDX_W-1:0]            waddr,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [lst_pkg::COUNT_W-1:0] wr_count,
	input  logic [lst_pkg::STAMP_W-1:0] wr_stamp,
	input  logic                        re,
	input  logic [IDX_W-1:0]            raddr,
	output logic [ADDR_W-1:0]           rd_addr,
	output logic [lst_pkg::COUNT_W-1:0] rd_count,
	output logic [lst_pkg::STAMP_W-1:0] rd_stamp
);
	import lst_pkg::*;

	localparam int WORD_W = ADDR_W + COUNT_W + STAMP_W;

	logic [WORD_W-1:0] mem [TABLE_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wr_addr, wr_count, wr_stamp};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rd_addr  = rdata_q[WORD_W-1 -: ADDR_W];
	assign rd_count = rdata_q[STAMP_W +: COUNT_W];
	assign rd_stamp = rdata_q[STAMP_W-1:0];

endmodule
